// ===== hw/rtl/p2rgb_pkg.sv =====
// Shared types and constants for the palette to packed RGB converter.
// Used by the channel placement unit and the top level; no dependencies.
package p2rgb_pkg;

	// Field and store sizes that are fixed by the pixel format.
	localparam int unsigned MASK_W    = 32;
	localparam int unsigned CHAN_W    = 8;
	localparam int unsigned RGB_W     = 3 * CHAN_W;
	localparam int unsigned PAL_DEPTH = 256;
	localparam int unsigned PAL_AW    = 8;

	// Operation codes of an input item.
	typedef enum logic [1:0] {
		ACT_WRITE  = 2'd0,
		ACT_INDEX  = 2'd1,
		ACT_DIRECT = 2'd2
	} action_t;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_RED   = 2'd0,
		REG_GREEN = 2'd1,
		REG_BLUE  = 2'd2
	} cfg_reg_t;

	// Palette special indexes.
	localparam logic [PAL_AW-1:0] IDX_BLACK = 8'd0;
	localparam logic [PAL_AW-1:0] IDX_WHITE = 8'd255;

	// One palette entry: red in the top byte, blue in the bottom byte.
	typedef struct packed {
		logic [CHAN_W-1:0] r;
		logic [CHAN_W-1:0] g;
		logic [CHAN_W-1:0] b;
	} rgb_t;

endpackage

// ===== hw/rtl/p2rgb_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; read data holds while the read enable is low.
module p2rgb_ram #(
	parameter int unsigned WIDTH = 24,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/p2rgb_chan.sv =====
// One color channel: mask analysis, scaling of an 8-bit value to the mask width,
// and placement into the packed word. Depends on p2rgb_pkg.
module p2rgb_chan (
	input  logic                          clk,
	input  logic                          adv,
	input  logic [p2rgb_pkg::MASK_W-1:0]  mask,
	input  logic [p2rgb_pkg::CHAN_W-1:0]  value,
	output logic [p2rgb_pkg::MASK_W-1:0]  placed
);

	logic [p2rgb_pkg::MASK_W-1:0] low1;
	logic [p2rgb_pkg::MASK_W-1:0] rev;
	logic [p2rgb_pkg::MASK_W-1:0] high1;
	logic [4:0]                   lo_idx;
	logic [4:0]                   rev_idx;
	logic [4:0]                   hi_idx;
	logic [5:0]                   wid;

	logic [4:0]                   sh_q;
	logic [2:0]                   bytes_q;
	logic [2:0]                   bits_q;

	logic [p2rgb_pkg::MASK_W-1:0] rep;
	logic [38:0]                  rep_sh;
	logic [14:0]                  frac_num;
	logic [15:0]                  frac_div;
	logic [p2rgb_pkg::MASK_W-1:0] scaled;
	logic [p2rgb_pkg::MASK_W-1:0] scaled_s2;

	// Find the lowest and highest set bits of the mask by isolating the lowest
	// one of the mask and of its bit reversal, then encoding those one-hot words.
	always_comb begin
		low1 = mask & (~mask + 32'd1);
		for (int i = 0; i < 32; i++) begin
			rev[i] = mask[31-i];
		end
		high1   = rev & (~rev + 32'd1);
		lo_idx  = 5'd0;
		rev_idx = 5'd0;
		for (int i = 0; i < 32; i++) begin
			if (low1[i]) begin
				lo_idx = lo_idx | 5'(i);
			end
			if (high1[i]) begin
				rev_idx = rev_idx | 5'(i);
			end
		end
		hi_idx = 5'd31 - rev_idx;
		wid    = 6'(hi_idx) - 6'(lo_idx) + 6'd1;
	end

	// The user must change the mask only while idle; the block does not enforce it.
	// Its shift and width are registered and split into whole bytes and leftover bits.
	always_ff @(posedge clk) begin
		sh_q    <= lo_idx;
		bytes_q <= wid[5:3];
		bits_q  <= wid[2:0];
	end

	// With width w = 8*a + b, v*(2^w-1)/255 equals v repeated a times, shifted
	// left by b, plus floor(v*(2^b-1)/255). The second term is below 2^b, so the
	// two parts are simply ORed. The small quotient uses the identity, exact for the
	// 15-bit numerator y, floor(y/255) = (y + (y >> 8) + 1) >> 8.
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			rep[8*k +: 8] = (3'(k) < bytes_q) ? value : 8'd0;
		end
		rep_sh   = {7'd0, rep} << bits_q;
		frac_num = ({7'd0, value} << bits_q) - {7'd0, value};
		frac_div = {1'b0, frac_num} + {9'd0, frac_num[14:8]} + 16'd1;
		scaled   = rep_sh[31:0] | {25'd0, frac_div[14:8]};
	end

	// Scaled value register.
	always_ff @(posedge clk) begin
		if (adv) begin
			scaled_s2 <= scaled;
		end
	end

	// Shift into place and keep only the mask bits; a zero mask gives zero.
	assign placed = (scaled_s2 << sh_q) & mask;

endmodule

// ===== hw/rtl/palette_to_packed_rgb_top.sv =====
// A converted pixel passes the palette read register, the channel scaled value registers
// and the output register. One item per cycle while the output is not stalled; each item
// makes at most one palette access, so nothing inside the pipeline holds an item back.
// The whole pipeline stalls together only when the output register is full and not taken.
// Reset clears the pipeline valid flags and loads the masks for 8:8:8 RGB in the low 24 bits.
// Palette contents are not cleared by reset and read as unknown until written.
module palette_to_packed_rgb_top #(
	parameter int unsigned PIXEL_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// Configuration write channel.
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [1:0]             cfg_index,
	input  logic [31:0]            cfg_data,
	// Input item channel.
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [1:0]             action,
	input  logic [7:0]             color_index,
	input  logic [7:0]             red_in,
	input  logic [7:0]             green_in,
	input  logic [7:0]             blue_in,
	// Result channel.
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [PIXEL_WIDTH-1:0] packed_pixel
);

	// Source of the color of an item in the first stage.
	typedef enum logic [1:0] {
		SRC_RAM    = 2'd0,
		SRC_BLACK  = 2'd1,
		SRC_WHITE  = 2'd2,
		SRC_DIRECT = 2'd3
	} src_t;

	logic [p2rgb_pkg::MASK_W-1:0] red_mask_q;
	logic [p2rgb_pkg::MASK_W-1:0] green_mask_q;
	logic [p2rgb_pkg::MASK_W-1:0] blue_mask_q;

	logic                         adv;
	logic                         acc;
	logic                         is_write;
	logic                         is_index;
	logic                         is_conv;
	src_t                         src_in;
	p2rgb_pkg::rgb_t              direct_in;
	logic [p2rgb_pkg::RGB_W-1:0]  pal_rdata;

	logic                         valid_s1;
	src_t                         src_s1;
	p2rgb_pkg::rgb_t              direct_s1;
	p2rgb_pkg::rgb_t              rgb_sel;
	logic                         valid_s2;

	logic [p2rgb_pkg::MASK_W-1:0] red_placed;
	logic [p2rgb_pkg::MASK_W-1:0] green_placed;
	logic [p2rgb_pkg::MASK_W-1:0] blue_placed;
	logic [p2rgb_pkg::MASK_W-1:0] packed_all;

	logic                         out_valid_q;
	logic [PIXEL_WIDTH-1:0]       packed_pixel_q;

	// Configuration writes are always taken; an index past the list is ignored.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_mask_q   <= 32'h00FF_0000;
			green_mask_q <= 32'h0000_FF00;
			blue_mask_q  <= 32'h0000_00FF;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				p2rgb_pkg::REG_RED:   red_mask_q   <= cfg_data;
				p2rgb_pkg::REG_GREEN: green_mask_q <= cfg_data;
				p2rgb_pkg::REG_BLUE:  blue_mask_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// The pipeline moves whenever the output register is empty or being taken.
	assign adv      = !out_valid_q || out_ready;
	assign in_ready = adv;
	assign acc      = in_valid && adv;

	// Decode the operation of the incoming item.
	always_comb begin
		is_write = 1'b0;
		is_index = 1'b0;
		unique case (action)
			p2rgb_pkg::ACT_WRITE:  is_write = 1'b1;
			p2rgb_pkg::ACT_INDEX:  is_index = 1'b1;
			p2rgb_pkg::ACT_DIRECT: ;
			default: ;
		endcase
		is_conv = is_index || (action == p2rgb_pkg::ACT_DIRECT);
		priority if (!is_index) begin
			src_in = SRC_DIRECT;
		end else if (color_index == p2rgb_pkg::IDX_BLACK) begin
			src_in = SRC_BLACK;
		end else if (color_index == p2rgb_pkg::IDX_WHITE) begin
			src_in = SRC_WHITE;
		end else begin
			src_in = SRC_RAM;
		end
		direct_in = '{r: red_in, g: green_in, b: blue_in};
	end

	// Palette store. A write and a later read of the same entry are at least one
	// transfer apart, so the read always sees the written data.
	p2rgb_ram #(
		.WIDTH(p2rgb_pkg::RGB_W),
		.DEPTH(p2rgb_pkg::PAL_DEPTH)
	) u_palette (
		.clk   (clk),
		.we    (acc && is_write),
		.waddr (color_index),
		.wdata (direct_in),
		.re    (acc && is_index),
		.raddr (color_index),
		.rdata (pal_rdata)
	);

	// First stage: the palette read is in flight.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= acc && is_conv;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			src_s1    <= src_in;
			direct_s1 <= direct_in;
		end
	end

	// Choose the color for the item: palette data, forced black or white, or direct.
	always_comb begin
		unique case (src_s1)
			SRC_RAM:    rgb_sel = p2rgb_pkg::rgb_t'(pal_rdata);
			SRC_BLACK:  rgb_sel = '0;
			SRC_WHITE:  rgb_sel = '1;
			SRC_DIRECT: rgb_sel = direct_s1;
			default:    rgb_sel = direct_s1;
		endcase
	end

	// Second stage: the scaled channel values sit inside the channel units.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	p2rgb_chan u_red (
		.clk    (clk),
		.adv    (adv),
		.mask   (red_mask_q),
		.value  (rgb_sel.r),
		.placed (red_placed)
	);

	p2rgb_chan u_green (
		.clk    (clk),
		.adv    (adv),
		.mask   (green_mask_q),
		.value  (rgb_sel.g),
		.placed (green_placed)
	);

	p2rgb_chan u_blue (
		.clk    (clk),
		.adv    (adv),
		.mask   (blue_mask_q),
		.value  (rgb_sel.b),
		.placed (blue_placed)
	);

	assign packed_all = red_placed | green_placed | blue_placed;

	// Output register, limited to the pixel width.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			packed_pixel_q <= packed_all[PIXEL_WIDTH-1:0];
		end
	end

	assign out_valid    = out_valid_q;
	assign packed_pixel = packed_pixel_q;

endmodule
